// ===== design/wcle_pkg.sv =====
// shared types, constants and character encoder for the wide char literal escaper
package wcle_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_X   = 8'h78;

  localparam logic [2:0] LEN_ONE   = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_OCTAL = 3'd4;

  // one escaped character: byte count and up to six bytes, first byte lowest
  typedef struct packed {
    logic [2:0]      len;
    logic [5:0][7:0] bytes;
  } desc_t;

  // head of the queue as seen by the back end
  typedef struct packed {
    logic  valid;
    desc_t desc;
  } q_head_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + {4'd0, d};
    end else begin
      r = CH_LC_A + {4'd0, d} - 8'd10;
    end
    return r;
  endfunction

  function automatic desc_t encode_char(input logic [15:0] ch);
    desc_t      d;
    logic [7:0] letter;
    logic [2:0] ndig;
    d.len   = LEN_ONE;
    d.bytes = '0;
    letter  = 8'h00;
    ndig    = 3'd1;
    case (ch)
      16'd7:   letter = 8'h61; // a
      16'd8:   letter = 8'h62; // b
      16'd12:  letter = 8'h66; // f
      16'd10:  letter = 8'h6e; // n
      16'd13:  letter = 8'h72; // r
      16'd9:   letter = 8'h74; // t
      16'd11:  letter = 8'h76; // v
      default: letter = 8'h00;
    endcase
    if (ch == {8'd0, CH_BSLASH}) begin
      d.len      = LEN_TWO;
      d.bytes[0] = CH_BSLASH;
      d.bytes[1] = CH_BSLASH;
    end else if (ch == {8'd0, CH_QUOTE}) begin
      d.len      = LEN_TWO;
      d.bytes[0] = CH_QUOTE;
      d.bytes[1] = CH_QUOTE;
    end else if (ch >= 16'h0020 && ch <= 16'h007e) begin
      d.len      = LEN_ONE;
      d.bytes[0] = ch[7:0];
    end else if (ch <= 16'h00ff) begin
      d.bytes[0] = CH_BSLASH;
      if (letter != 8'h00) begin
        d.len      = LEN_TWO;
        d.bytes[1] = letter;
      end else begin
        d.len      = LEN_OCTAL;
        d.bytes[1] = CH_ZERO + {6'd0, ch[7:6]};
        d.bytes[2] = CH_ZERO + {5'd0, ch[5:3]};
        d.bytes[3] = CH_ZERO + {5'd0, ch[2:0]};
      end
    end else begin
      // codes of 0x100 and up always have at least three hex digits
      d.bytes[0] = CH_BSLASH;
      d.bytes[1] = CH_LC_X;
      if (ch[15:12] != 4'd0) begin
        ndig       = 3'd4;
        d.bytes[2] = hex_digit(ch[15:12]);
        d.bytes[3] = hex_digit(ch[11:8]);
        d.bytes[4] = hex_digit(ch[7:4]);
        d.bytes[5] = hex_digit(ch[3:0]);
      end else begin
        ndig       = 3'd3;
        d.bytes[2] = hex_digit(ch[11:8]);
        d.bytes[3] = hex_digit(ch[7:4]);
        d.bytes[4] = hex_digit(ch[3:0]);
      end
      d.len = LEN_TWO + ndig;
    end
    return d;
  endfunction

endpackage

// ===== design/wcle_front.sv =====
// front end: string tracking, end detection and encoding of each character
module wcle_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [31:0]   in_tdata,
  input  logic [1:0]    in_tuser,
  input  logic          q_full,
  output logic          push,
  output wcle_pkg::desc_t push_desc
);

  logic [15:0] remaining_r, remaining_nxt;
  logic        nul_mode_r, nul_mode_nxt;
  logic        finished_r, finished_nxt;
  logic        accept;
  logic        emit;
  logic [15:0] code;
  logic [15:0] cnt;
  logic        start;
  logic        until_nul;

  assign code      = in_tdata[15:0];
  assign cnt       = in_tdata[31:16];
  assign start     = in_tuser[0];
  assign until_nul = in_tuser[1];
  assign in_tready = ~q_full;
  assign accept    = in_tvalid & in_tready;
  assign push      = accept & emit;
  assign push_desc = wcle_pkg::encode_char(code);

  always_comb begin
    remaining_nxt = remaining_r;
    nul_mode_nxt  = nul_mode_r;
    finished_nxt  = finished_r;
    emit          = 1'b0;
    if (start) begin
      remaining_nxt = cnt;
      nul_mode_nxt  = until_nul;
      finished_nxt  = 1'b0;
    end
    if (!finished_nxt) begin
      if (nul_mode_nxt) begin
        if (code == 16'd0) begin
          finished_nxt = 1'b1;
        end else begin
          emit = 1'b1;
        end
      end else if (remaining_nxt == 16'd0) begin
        finished_nxt = 1'b1;
      end else begin
        remaining_nxt = remaining_nxt - 16'd1;
        emit          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r <= '0;
      nul_mode_r  <= 1'b0;
      finished_r  <= 1'b1;
    end else if (accept) begin
      remaining_r <= remaining_nxt;
      nul_mode_r  <= nul_mode_nxt;
      finished_r  <= finished_nxt;
    end
  end

  // a finished string without a new start never produces bytes
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && finished_r && !start) |-> !push)
    else $error("push on finished string");

  // count mode consumes one from remaining per emitted character
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !nul_mode_nxt) |=> (remaining_r == $past(remaining_nxt)))
    else $error("remaining not updated");

endmodule

// ===== design/wcle_queue.sv =====
// short descriptor queue between front and back ends
module wcle_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wcle_pkg::desc_t   push_desc,
  input  logic              pop,
  output logic              full,
  output wcle_pkg::q_head_t head
);

  wcle_pkg::desc_t                   mem [wcle_pkg::QDEPTH];
  logic [wcle_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [wcle_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;

  assign full       = (cnt_r == wcle_pkg::QCNT_W'(wcle_pkg::QDEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.desc  = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + wcle_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - wcle_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + wcle_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + wcle_pkg::QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue overflow");

  assert property (@(posedge clk) disable iff (!rst_n) pop |-> head.valid)
    else $error("queue underflow");

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= wcle_pkg::QCNT_W'(wcle_pkg::QDEPTH))
    else $error("queue count out of range");

endmodule

// ===== design/wcle_back.sv =====
// back end: serializes the bytes of each queued character into the output register
module wcle_back (
  input  logic              clk,
  input  logic              rst_n,
  input  wcle_pkg::q_head_t head,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast
);

  logic [2:0] idx_r;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load;
  logic       is_last;

  assign load       = head.valid & (~valid_r | out_tready);
  assign is_last    = (idx_r == head.desc.len - 3'd1);
  assign pop        = load & is_last;
  assign out_tvalid = valid_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head.desc.bytes[idx_r];
      last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= is_last ? 3'd0 : idx_r + 3'd1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // byte index never runs past the length of the character being sent
  assert property (@(posedge clk) disable iff (!rst_n)
    head.valid |-> (idx_r < head.desc.len))
    else $error("byte index past length");

  // index returns to zero once a character is fully handed over
  assert property (@(posedge clk) disable iff (!rst_n) pop |=> (idx_r == 3'd0))
    else $error("index not rewound");

endmodule

// ===== design/wide_char_literal_escaper.sv =====
// top level of the wide char literal escaper
// path: an accepted beat is queued, then its bytes load into the output register
// throughput: one input beat per cycle while the four-entry queue has room;
//   one byte out per cycle while out_tready is high; a character is one to six bytes
// reset: synchronous active-low rst_n empties the queue and output register and
//   marks the string as finished, so only a beat with start set produces bytes
module wide_char_literal_escaper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // code [15:0], count [31:16]
  input  logic [1:0]  in_tuser,   // start_req [0], until_nul [1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte [7:0]
  output logic        out_tlast   // last byte of the escaped character
);

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  wcle_pkg::desc_t   q_desc;
  wcle_pkg::q_head_t q_head;

  // front: tracks string state, drops ended characters, encodes the rest
  wcle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (q_push),
    .push_desc (q_desc)
  );

  // decoupling queue, lets the input keep flowing while long escapes drain
  wcle_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_desc),
    .pop       (q_pop),
    .full      (q_full),
    .head      (q_head)
  );

  // back: walks the bytes of the head character into the output register
  wcle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
